/* hw/rtl/bsc_pkg.sv */
`default_nettype none

package bsc_pkg;

	localparam int unsigned SideW = 64;
	localparam int unsigned DivStages = 32;

	localparam logic [31:0] TempOffset = 32'd4000;
	localparam logic [31:0] CoefA = 32'd3038;
	localparam logic [31:0] CoefB = 32'd0 - 32'd7357;
	localparam logic [31:0] CoefC = 32'd3791;
	localparam logic [31:0] PressScale = 32'd50000;
	localparam logic [31:0] B4Offset = 32'd32768;
	localparam logic [31:0] PressMax = 32'd262143;

	typedef enum logic [2:0] {
		RegAcSigned   = 3'd0,
		RegAcUnsigned = 3'd1,
		RegBPair      = 3'd2,
		RegMcMd       = 3'd3,
		RegOss        = 3'd4,
		RegCalValid   = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		StOk      = 2'd0,
		StNoCal   = 2'd1,
		StZeroDiv = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] x1;
		logic [23:0] rawp;
		logic        den_zero;
		logic        neg;
		logic [5:0]  pad;
	} temp_side_t;

	typedef struct packed {
		logic [15:0] t16;
		logic        den_zero;
		logic        b4_zero;
		logic        post_shl;
		logic [44:0] pad;
	} press_side_t;

	function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] full;
		full = a * b;
		return full[31:0];
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/bsc_udiv.sv */
`default_nettype none

// Unsigned 32-bit restoring divider, one quotient bit per stage.
module bsc_udiv (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      adv,
	input  wire logic                      in_valid,
	input  wire logic [31:0]               num,
	input  wire logic [31:0]               den,
	input  wire logic [bsc_pkg::SideW-1:0] side,
	output logic                           out_valid,
	output logic [31:0]                    quo,
	output logic [bsc_pkg::SideW-1:0]      side_out
);

	logic [31:0]               rem_sn  [bsc_pkg::DivStages];
	logic [31:0]               quo_sn  [bsc_pkg::DivStages];
	logic [31:0]               dvs_sn  [bsc_pkg::DivStages];
	logic [bsc_pkg::SideW-1:0] side_sn [bsc_pkg::DivStages];
	logic                      v_sn    [bsc_pkg::DivStages];

	for (genvar k = 0; k < bsc_pkg::DivStages; k++) begin : g_stage
		logic [31:0]               r_i;
		logic [31:0]               n_i;
		logic [31:0]               d_i;
		logic [bsc_pkg::SideW-1:0] s_i;
		logic                      v_i;
		logic [32:0]               trial;
		logic                      ge;
		logic [32:0]               diff;

		if (k == 0) begin : g_first
			assign r_i = '0;
			assign n_i = num;
			assign d_i = den;
			assign s_i = side;
			assign v_i = in_valid;
		end else begin : g_next
			assign r_i = rem_sn[k-1];
			assign n_i = quo_sn[k-1];
			assign d_i = dvs_sn[k-1];
			assign s_i = side_sn[k-1];
			assign v_i = v_sn[k-1];
		end

		assign trial = {r_i, n_i[31]};
		assign ge    = trial >= {1'b0, d_i};
		assign diff  = trial - {1'b0, d_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[k] <= 1'b0;
			end else if (adv) begin
				v_sn[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sn[k]  <= ge ? diff[31:0] : trial[31:0];
				quo_sn[k]  <= {n_i[30:0], ge};
				dvs_sn[k]  <= d_i;
				side_sn[k] <= s_i;
			end
		end
	end

	assign out_valid = v_sn[bsc_pkg::DivStages-1];
	assign quo       = quo_sn[bsc_pkg::DivStages-1];
	assign side_out  = side_sn[bsc_pkg::DivStages-1];

endmodule

`default_nettype wire

/* hw/rtl/bsc_pcorr.sv */
`default_nettype none

// Second-order pressure correction, clamping and result register.
module bsc_pcorr (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 in_valid,
	input  wire logic [31:0]          quo,
	input  wire bsc_pkg::press_side_t side,
	input  wire logic                 cal_valid,
	output logic                      out_valid,
	output logic [1:0]                status,
	output logic signed [15:0]        temperature_tenths,
	output logic [17:0]               pressure_pascal
);

	bsc_pkg::press_side_t side_s1, side_s2, side_s3, side_s4;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [31:0] p_s1, p_s2, p_s3, pf_s4;
	logic [31:0] m1_s2, m2_s2, m3_s3, x2_s3;
	logic [1:0]  status_s5;
	logic [15:0] temp_s5;
	logic [17:0] pres_s5;

	logic [31:0] x1_c;
	logic [17:0] clamp_c;

	assign x1_c = bsc_pkg::asr32(p_s1, 5'd8);

	always_comb begin
		if (pf_s4[31]) begin
			clamp_c = '0;
		end else if (pf_s4 > bsc_pkg::PressMax) begin
			clamp_c = bsc_pkg::PressMax[17:0];
		end else begin
			clamp_c = pf_s4[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1    <= side.post_shl ? {quo[30:0], 1'b0} : quo;
			side_s1 <= side;
			m1_s2   <= bsc_pkg::mul32(x1_c, x1_c);
			m2_s2   <= bsc_pkg::mul32(bsc_pkg::CoefB, p_s1);
			p_s2    <= p_s1;
			side_s2 <= side_s1;
			m3_s3   <= bsc_pkg::mul32(m1_s2, bsc_pkg::CoefA);
			x2_s3   <= bsc_pkg::asr32(m2_s2, 5'd16);
			p_s3    <= p_s2;
			side_s3 <= side_s2;
			pf_s4   <= p_s3 + bsc_pkg::asr32(bsc_pkg::asr32(m3_s3, 5'd16) + x2_s3
				+ bsc_pkg::CoefC, 5'd4);
			side_s4 <= side_s3;
			if (!cal_valid) begin
				status_s5 <= bsc_pkg::StNoCal;
				temp_s5   <= '0;
				pres_s5   <= '0;
			end else if (side_s4.den_zero) begin
				status_s5 <= bsc_pkg::StZeroDiv;
				temp_s5   <= '0;
				pres_s5   <= '0;
			end else if (side_s4.b4_zero) begin
				status_s5 <= bsc_pkg::StZeroDiv;
				temp_s5   <= side_s4.t16;
				pres_s5   <= '0;
			end else begin
				status_s5 <= bsc_pkg::StOk;
				temp_s5   <= side_s4.t16;
				pres_s5   <= clamp_c;
			end
		end
	end

	assign out_valid          = v_s5;
	assign status             = status_s5;
	assign temperature_tenths = temp_s5;
	assign pressure_pascal    = pres_s5;

endmodule

`default_nettype wire

/* hw/rtl/barometric_sensor_compensation.sv */
// Accepts one transaction per cycle while out_stall is not holding a waiting result;
// the two 32-stage dividers make up most of the depth.
// The whole pipeline holds while a result waits under out_stall.
// Reset clears all valid bits and the configuration (oversampling resets to three).
`default_nettype none

module barometric_sensor_compensation (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [15:0]        raw_temperature,
	input  wire logic [23:0]        raw_pressure_bytes,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic signed [15:0]      temperature_tenths,
	output logic [17:0]             pressure_pascal,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [47:0]        cfg_data
);

	logic [47:0] ac_s_q, ac_u_q;
	logic [31:0] b_pair_q, mc_md_q;
	logic [1:0]  oss_q;
	logic        cal_valid_q;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic adv;

	assign ac1 = bsc_pkg::sext16(ac_s_q[15:0]);
	assign ac2 = bsc_pkg::sext16(ac_s_q[31:16]);
	assign ac3 = bsc_pkg::sext16(ac_s_q[47:32]);
	assign ac4 = {16'b0, ac_u_q[15:0]};
	assign ac5 = {16'b0, ac_u_q[31:16]};
	assign ac6 = {16'b0, ac_u_q[47:32]};
	assign b1  = bsc_pkg::sext16(b_pair_q[15:0]);
	assign b2  = bsc_pkg::sext16(b_pair_q[31:16]);
	assign mc  = bsc_pkg::sext16(mc_md_q[15:0]);
	assign md  = bsc_pkg::sext16(mc_md_q[31:16]);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_s_q      <= '0;
			ac_u_q      <= '0;
			b_pair_q    <= '0;
			mc_md_q     <= '0;
			oss_q       <= 2'd3;
			cal_valid_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bsc_pkg::RegAcSigned:   ac_s_q      <= cfg_data;
				bsc_pkg::RegAcUnsigned: ac_u_q      <= cfg_data;
				bsc_pkg::RegBPair:      b_pair_q    <= cfg_data[31:0];
				bsc_pkg::RegMcMd:       mc_md_q     <= cfg_data[31:0];
				bsc_pkg::RegOss:        oss_q       <= cfg_data[1:0];
				bsc_pkg::RegCalValid:   cal_valid_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic out_valid_w;
	assign adv      = !(out_valid_w && out_stall);
	assign in_stall = !adv;

	// Temperature front end.
	logic        v_s1, v_s2, v_s3;
	logic [15:0] ut_s1;
	logic [23:0] rawp_s1, rawp_s2, rawp_s3;
	logic [31:0] tprod_s2, x1_s3, den_s3;
	logic [31:0] x1_c, num_c, num_mag, den_mag;
	bsc_pkg::temp_side_t tside_in, tside_out;
	logic        tdiv_v;
	logic [31:0] tquo;
	logic [bsc_pkg::SideW-1:0] tside_raw;

	assign x1_c    = bsc_pkg::asr32(tprod_s2, 5'd15);
	assign num_c   = {mc[20:0], 11'b0};
	assign num_mag = mc[15] ? 32'd0 - num_c : num_c;
	assign den_mag = den_s3[31] ? 32'd0 - den_s3 : den_s3;

	always_comb begin
		tside_in          = '0;
		tside_in.x1       = x1_s3;
		tside_in.rawp     = rawp_s3;
		tside_in.den_zero = den_s3 == 32'd0;
		tside_in.neg      = mc[15] ^ den_s3[31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ut_s1    <= raw_temperature;
			rawp_s1  <= raw_pressure_bytes;
			tprod_s2 <= bsc_pkg::mul32({16'b0, ut_s1} - ac6, ac5);
			rawp_s2  <= rawp_s1;
			x1_s3    <= x1_c;
			den_s3   <= x1_c + md;
			rawp_s3  <= rawp_s2;
		end
	end

	bsc_udiv u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (v_s3),
		.num      (num_mag),
		.den      (den_mag),
		.side     (tside_in),
		.out_valid(tdiv_v),
		.quo      (tquo),
		.side_out (tside_raw)
	);

	assign tside_out = bsc_pkg::temp_side_t'(tside_raw);

	// Pressure coefficient chain.
	logic        v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic [31:0] b5_s4, b6_s5, sqp_s6, a2p_s6, a3p_s6;
	logic [31:0] sq_s7, x2a_s7, x1c_s7;
	logic [31:0] b2sq_s8, b1sq_s8, x2a_s8, x1c_s8;
	logic [31:0] x3_s9, x3b_s9;
	logic [31:0] b3_s10, t4_s10, up_s10;
	logic [31:0] dif_s11, b4p_s11;
	logic [31:0] b7_s12, b4_s12;
	logic [15:0] t16_s5, t16_s6, t16_s7, t16_s8, t16_s9, t16_s10, t16_s11, t16_s12;
	logic [23:0] rawp_s4, rawp_s5, rawp_s6, rawp_s7, rawp_s8, rawp_s9;
	logic        dz_s4, dz_s5, dz_s6, dz_s7, dz_s8, dz_s9, dz_s10, dz_s11, dz_s12;

	logic [31:0] x2_c, t_c, up_c;
	logic [15:0] t16_c;
	logic [3:0]  up_sh;

	assign x2_c  = tside_out.neg ? 32'd0 - tquo : tquo;
	assign t_c   = bsc_pkg::asr32(b5_s4 + 32'd8, 5'd4);
	assign up_sh = 4'd8 - {2'b0, oss_q};
	assign up_c  = {8'b0, rawp_s9} >> up_sh;

	always_comb begin
		if (!t_c[31] && t_c[30:15] != 16'h0000) begin
			t16_c = 16'h7FFF;
		end else if (t_c[31] && t_c[30:15] != 16'hFFFF) begin
			t16_c = 16'h8000;
		end else begin
			t16_c = t_c[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (adv) begin
			v_s4  <= tdiv_v;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b5_s4   <= tside_out.x1 + x2_c;
			rawp_s4 <= tside_out.rawp;
			dz_s4   <= tside_out.den_zero;

			b6_s5   <= b5_s4 - bsc_pkg::TempOffset;
			t16_s5  <= t16_c;
			rawp_s5 <= rawp_s4;
			dz_s5   <= dz_s4;

			sqp_s6  <= bsc_pkg::mul32(b6_s5, b6_s5);
			a2p_s6  <= bsc_pkg::mul32(ac2, b6_s5);
			a3p_s6  <= bsc_pkg::mul32(ac3, b6_s5);
			t16_s6  <= t16_s5;
			rawp_s6 <= rawp_s5;
			dz_s6   <= dz_s5;

			sq_s7   <= bsc_pkg::asr32(sqp_s6, 5'd12);
			x2a_s7  <= bsc_pkg::asr32(a2p_s6, 5'd11);
			x1c_s7  <= bsc_pkg::asr32(a3p_s6, 5'd13);
			t16_s7  <= t16_s6;
			rawp_s7 <= rawp_s6;
			dz_s7   <= dz_s6;

			b2sq_s8 <= bsc_pkg::mul32(b2, sq_s7);
			b1sq_s8 <= bsc_pkg::mul32(b1, sq_s7);
			x2a_s8  <= x2a_s7;
			x1c_s8  <= x1c_s7;
			t16_s8  <= t16_s7;
			rawp_s8 <= rawp_s7;
			dz_s8   <= dz_s7;

			x3_s9   <= bsc_pkg::asr32(b2sq_s8, 5'd11) + x2a_s8;
			x3b_s9  <= bsc_pkg::asr32(x1c_s8 + bsc_pkg::asr32(b1sq_s8, 5'd16) + 32'd2, 5'd2);
			t16_s9  <= t16_s8;
			rawp_s9 <= rawp_s8;
			dz_s9   <= dz_s8;

			b3_s10  <= bsc_pkg::asr32((({ac1[29:0], 2'b00} + x3_s9) << oss_q) + 32'd2, 5'd2);
			t4_s10  <= x3b_s9 + bsc_pkg::B4Offset;
			up_s10  <= up_c;
			t16_s10 <= t16_s9;
			dz_s10  <= dz_s9;

			dif_s11 <= up_s10 - b3_s10;
			b4p_s11 <= bsc_pkg::mul32(ac4, t4_s10);
			t16_s11 <= t16_s10;
			dz_s11  <= dz_s10;

			b7_s12  <= bsc_pkg::mul32(dif_s11, bsc_pkg::PressScale >> oss_q);
			b4_s12  <= b4p_s11 >> 15;
			t16_s12 <= t16_s11;
			dz_s12  <= dz_s11;
		end
	end

	bsc_pkg::press_side_t pside_in;
	logic [31:0] pnum;
	logic        pdiv_v;
	logic [31:0] pquo;
	logic [bsc_pkg::SideW-1:0] pside_raw;

	assign pnum = b7_s12[31] ? b7_s12 : {b7_s12[30:0], 1'b0};

	always_comb begin
		pside_in          = '0;
		pside_in.t16      = t16_s12;
		pside_in.den_zero = dz_s12;
		pside_in.b4_zero  = b4_s12 == 32'd0;
		pside_in.post_shl = b7_s12[31];
	end

	bsc_udiv u_pdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (v_s12),
		.num      (pnum),
		.den      (b4_s12),
		.side     (pside_in),
		.out_valid(pdiv_v),
		.quo      (pquo),
		.side_out (pside_raw)
	);

	bsc_pcorr u_pcorr (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (adv),
		.in_valid          (pdiv_v),
		.quo               (pquo),
		.side              (bsc_pkg::press_side_t'(pside_raw)),
		.cal_valid         (cal_valid_q),
		.out_valid         (out_valid_w),
		.status            (status),
		.temperature_tenths(temperature_tenths),
		.pressure_pascal   (pressure_pascal)
	);

	assign out_valid = out_valid_w;

endmodule

`default_nettype wire

/* sim/tb_barometric_sensor_compensation.sv */
`default_nettype none

module tb_barometric_sensor_compensation;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] RegUnused = 3'd7;
	localparam int HoldOffCycles = 1500;
	localparam int IdleLimit = 20000;
	localparam int DrainCycles = 120;

	typedef enum int {
		StallNever,
		StallLight,
		StallHeavy
	} stall_mode_t;

	typedef struct packed {
		bsc_pkg::status_t   st;
		logic signed [15:0] temp;
		logic [17:0]        pres;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] raw_temperature = '0;
	logic [23:0] raw_pressure_bytes = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic signed [15:0] temperature_tenths;
	logic [17:0] pressure_pascal;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [47:0] cfg_data = '0;

	logic [47:0] ac_signed_q = '0;
	logic [47:0] ac_unsigned_q = '0;
	logic [31:0] b_pair_q = '0;
	logic [31:0] mc_md_q = '0;
	logic [1:0] oss_q = 2'd3;
	logic cal_valid_q = 1'b0;

	reading_t pending_readings[$];
	int error_count = 0;
	int burst_left = 0;
	bit gaps_enabled = 1'b1;
	bit hold_start = 1'b0;
	int hold_cycles = 0;
	int cycle_count = 0;
	int idle_cycles = 0;
	stall_mode_t stall_mode = StallNever;

	barometric_sensor_compensation uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_temperature(raw_temperature),
		.raw_pressure_bytes(raw_pressure_bytes),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.temperature_tenths(temperature_tenths),
		.pressure_pascal(pressure_pascal),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] shr_arith(input logic [31:0] x, input int n);
		return $unsigned($signed(x) >>> n);
	endfunction

	function automatic reading_t compensate(input logic [15:0] ut_raw, input logic [23:0] rawp);
		logic [31:0] ut, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, up, p;
		logic signed [31:0] t;
		reading_t r;
		r.st = bsc_pkg::StNoCal;
		r.temp = '0;
		r.pres = '0;
		if (!cal_valid_q)
			return r;
		ut = {16'd0, ut_raw};
		ac1 = $unsigned(32'($signed(ac_signed_q[15:0])));
		ac2 = $unsigned(32'($signed(ac_signed_q[31:16])));
		ac3 = $unsigned(32'($signed(ac_signed_q[47:32])));
		ac4 = {16'd0, ac_unsigned_q[15:0]};
		ac5 = {16'd0, ac_unsigned_q[31:16]};
		ac6 = {16'd0, ac_unsigned_q[47:32]};
		b1 = $unsigned(32'($signed(b_pair_q[15:0])));
		b2 = $unsigned(32'($signed(b_pair_q[31:16])));
		mc = $unsigned(32'($signed(mc_md_q[15:0])));
		md = $unsigned(32'($signed(mc_md_q[31:16])));

		x1 = shr_arith((ut - ac6) * ac5, 15);
		den = x1 + md;
		r.st = bsc_pkg::StZeroDiv;
		if (den == 32'd0)
			return r;
		x2 = $unsigned($signed(mc << 11) / $signed(den));
		b5 = x1 + x2;
		t = $signed(b5 + 32'd8) >>> 4;
		if (t > 32767)
			r.temp = 16'sh7fff;
		else if (t < -32768)
			r.temp = 16'sh8000;
		else
			r.temp = t[15:0];

		up = {8'd0, rawp} >> (8 - oss_q);
		b6 = b5 - bsc_pkg::TempOffset;
		sq = shr_arith(b6 * b6, 12);
		x1 = shr_arith(b2 * sq, 11);
		x2 = shr_arith(ac2 * b6, 11);
		x3 = x1 + x2;
		b3 = shr_arith(((ac1 * 32'd4 + x3) << oss_q) + 32'd2, 2);
		x1 = shr_arith(ac3 * b6, 13);
		x2 = shr_arith(b1 * sq, 16);
		x3 = shr_arith(x1 + x2 + 32'd2, 2);
		b4 = (ac4 * (x3 + bsc_pkg::B4Offset)) >> 15;
		if (b4 == 32'd0)
			return r;
		b7 = (up - b3) * (bsc_pkg::PressScale >> oss_q);
		p = b7[31] ? (b7 / b4) * 32'd2 : (b7 * 32'd2) / b4;
		x1 = shr_arith(p, 8);
		x1 = x1 * x1;
		x1 = shr_arith(x1 * bsc_pkg::CoefA, 16);
		x2 = shr_arith(bsc_pkg::CoefB * p, 16);
		p = p + shr_arith(x1 + x2 + bsc_pkg::CoefC, 4);
		r.st = bsc_pkg::StOk;
		if (p[31])
			r.pres = '0;
		else if (p > bsc_pkg::PressMax)
			r.pres = bsc_pkg::PressMax[17:0];
		else
			r.pres = p[17:0];
		return r;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			bsc_pkg::RegAcSigned: ac_signed_q = data;
			bsc_pkg::RegAcUnsigned: ac_unsigned_q = data;
			bsc_pkg::RegBPair: b_pair_q = data[31:0];
			bsc_pkg::RegMcMd: mc_md_q = data[31:0];
			bsc_pkg::RegOss: oss_q = data[1:0];
			bsc_pkg::RegCalValid: cal_valid_q = data[0];
			default: ;
		endcase
	endtask

	task automatic load_calibration(input logic [47:0] ac_s, input logic [47:0] ac_u,
			input logic [31:0] bp, input logic [31:0] mcmd, input logic [1:0] oss,
			input logic valid);
		write_reg(bsc_pkg::RegAcSigned, ac_s);
		write_reg(bsc_pkg::RegAcUnsigned, ac_u);
		write_reg(bsc_pkg::RegBPair, {16'd0, bp});
		write_reg(bsc_pkg::RegMcMd, {16'd0, mcmd});
		write_reg(bsc_pkg::RegOss, {46'd0, oss});
		write_reg(RegUnused, 48'({$urandom(), $urandom()}));
		write_reg(bsc_pkg::RegCalValid, {47'd0, valid});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_reading(input logic [15:0] ut, input logic [23:0] rawp);
		int gap;
		if (gaps_enabled && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		raw_temperature <= ut;
		raw_pressure_bytes <= rawp;
		do @(posedge clk); while (in_stall);
		pending_readings.push_back(compensate(ut, rawp));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		wait (pending_readings.size() == 0);
		@(posedge clk);
	endtask

	task automatic send_random_reading;
		if ($urandom_range(0, 4) != 0)
			send_reading(16'($urandom_range(20000, 40000)),
				24'($urandom_range(24'h400000, 24'hb00000)));
		else
			send_reading(16'($urandom()), 24'($urandom()));
	endtask

	function automatic logic [15:0] near(input int typical, input int spread);
		return 16'(typical + $urandom_range(0, 2 * spread) - spread);
	endfunction

	task automatic test_uncalibrated;
		send_reading(16'h0000, 24'h000000);
		send_reading(16'hffff, 24'hffffff);
		send_reading(16'h5555, 24'haaaaaa);
		drain();
	endtask

	task automatic test_typical_calibration;
		for (int oss = 0; oss < 4; oss++) begin
			load_calibration({16'(-14383), 16'(-72), 16'd408},
				{16'd23153, 16'd32757, 16'd32741}, {16'd4, 16'd6190},
				{16'd2868, 16'(-8711)}, 2'(oss), 1'b1);
			send_reading(16'd27898, 24'(23843 << 8));
			send_reading(16'h0000, 24'h000000);
			send_reading(16'hffff, 24'hffffff);
			send_reading(16'h0000, 24'hffffff);
			send_reading(16'hffff, 24'h000000);
			drain();
		end
	endtask

	task automatic test_zero_divisors;
		// With AC5 and MD both zero the temperature divisor vanishes.
		load_calibration({16'd0, 16'd0, 16'd408}, {16'd23153, 16'd0, 16'd32741},
			{16'd4, 16'd6190}, {16'd0, 16'(-8711)}, 2'd0, 1'b1);
		send_reading(16'd27898, 24'h5d2300);
		send_reading(16'hffff, 24'hffffff);
		drain();
		// A zero AC4 forces the pressure divisor to zero.
		load_calibration({16'(-14383), 16'(-72), 16'd408}, {16'd23153, 16'd32757, 16'd0},
			{16'd4, 16'd6190}, {16'd2868, 16'(-8711)}, 2'd3, 1'b1);
		send_reading(16'd27898, 24'h5d2300);
		send_reading(16'h8000, 24'h800000);
		drain();
	endtask

	task automatic test_random_calibrations;
		logic [1:0] oss;
		for (int phase = 0; phase < 12; phase++) begin
			oss = phase == 0 ? 2'd0 : phase == 1 ? 2'd3 : 2'($urandom_range(0, 3));
			if ($urandom_range(0, 9) < 7)
				load_calibration({near(-14383, 3000), near(-72, 500), near(408, 4000)},
					{near(23153, 8000), near(32757, 8000), near(32741, 8000)},
					{near(4, 200), near(6190, 3000)}, {near(2868, 1000), near(-8711, 3000)},
					oss, $urandom_range(0, 9) != 0);
			else
				load_calibration(48'({$urandom(), $urandom()}),
					48'({$urandom(), $urandom()}),
					$urandom(), $urandom(), oss, 1'b1);
			repeat (90) send_random_reading();
			drain();
		end
	endtask

	task automatic test_output_hold_off;
		load_calibration({16'(-14383), 16'(-72), 16'd408},
			{16'd23153, 16'd32757, 16'd32741}, {16'd4, 16'd6190},
			{16'd2868, 16'(-8711)}, 2'd1, 1'b1);
		gaps_enabled = 1'b0;
		hold_start = 1'b1;
		repeat (200) send_random_reading();
		gaps_enabled = 1'b1;
		drain();
	endtask

	always @(posedge clk) begin
		reading_t want;
		cycle_count++;
		if (cycle_count % 64 == 0)
			stall_mode = stall_mode_t'($urandom_range(0, 2));
		if (hold_start) begin
			hold_start = 1'b0;
			hold_cycles = HoldOffCycles;
		end
		if (out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result status %0d temp %0d pres %0d",
					$time, status, temperature_tenths, pressure_pascal);
			end else begin
				want = pending_readings.pop_front();
				if (status !== want.st) begin
					error_count++;
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
				end
				if (temperature_tenths !== want.temp) begin
					error_count++;
					$display("%0t: temperature expected %0d actual %0d",
						$time, want.temp, temperature_tenths);
				end
				if (pressure_pascal !== want.pres) begin
					error_count++;
					$display("%0t: pressure expected %0d actual %0d",
						$time, want.pres, pressure_pascal);
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				StallLight: out_stall <= $urandom_range(0, 3) == 0;
				StallHeavy: out_stall <= $urandom_range(0, 3) != 0;
				default: out_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_uncalibrated();
		test_typical_calibration();
		test_zero_divisors();
		test_random_calibrations();
		test_output_hold_off();
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0 && pending_readings.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
